/* rtl/apcd_pkg.sv */
// apcd_pkg: shared types, widths and constants of the allpass cascade block.
// No dependencies; imported by apcd_div and allpass_cascade_dispersion.
package apcd_pkg;

  localparam int SAMPLE_W    = 24;   // Q1.23 audio word
  localparam int ST_W        = 32;   // Q6.26 internal state
  localparam int COEFF_W     = 17;   // Q1.16 signed
  localparam int GAIN_W      = 16;   // Q0.16 unsigned
  localparam int CNT_W       = 4;    // stage count register
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int FRAC_W      = 26;
  localparam int COEFF_LIMIT = 64880;
  localparam int GAIN_LIMIT  = 62259;
  localparam int CLIP_K      = 19661; // 0.3 in Q0.16
  localparam int WIDE_W      = 51;    // sums before saturation

  // Soft clip divider: den < 2^38, dividend = mag*2^26 + den/2 < 2^59,
  // quotient is below 2^26 so 27 quotient bits always suffice.
  localparam int DEN_W       = 38;
  localparam int DVD_W       = 59;
  localparam int Q_W         = 27;
  localparam int DIV_CNT_W   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF = 2'd0,
    REG_COUNT = 2'd1,
    REG_GAIN  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FB_MUL,
    S_FB_ADD,
    S_RD,
    S_MUL,
    S_ACC,
    S_PUT,
    S_SQ,
    S_KMUL,
    S_DEN,
    S_DIV_GO,
    S_DIV
  } ap_state_t;

  // Saturate a wide signed sum to the 32-bit state range.
  function automatic logic signed [ST_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > $signed({{(WIDE_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}})) begin
      r = {1'b0, {(ST_W-1){1'b1}}};
    end else if (v < $signed({{(WIDE_W-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}})) begin
      r = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/apcd_div.sv */
// apcd_div: restoring divider, one quotient bit per cycle, for the soft clip.
// Depends on apcd_pkg (DEN_W, DVD_W, Q_W, DIV_CNT_W).
module apcd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [apcd_pkg::DVD_W-1:0]  dividend,
  input  logic [apcd_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [apcd_pkg::Q_W-1:0]    quotient
);
  import apcd_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     dsr_r;
  logic [Q_W-1:0]       lo_r;
  logic [Q_W-1:0]       quo_r;

  logic [DEN_W:0]       trial;
  logic                 ge;
  logic [DEN_W:0]       diff;
  logic [DEN_W-1:0]     rem_nxt;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial   = {rem_r, lo_r[Q_W-1]};
    ge      = (trial >= {1'b0, dsr_r});
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // The upper bits sit below the divisor since the quotient fits Q_W bits.
      rem_r <= DEN_W'(dividend[DVD_W-1:Q_W]);
      lo_r  <= dividend[Q_W-1:0];
      dsr_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[Q_W-2:0], 1'b0};
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !$past(start)) |-> (rem_r < dsr_r))
    else $error("divider remainder reached the divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule

/* rtl/allpass_cascade_dispersion.sv */
// allpass_cascade_dispersion: first-order allpass cascade with soft-clipped feedback.
// Depends on apcd_pkg and apcd_div.
// Flow: an accepted word gets the feedback term added, then per stage a read, multiply and write
//   back on the state memory; sample_out is loaded once the output slot is free, then the bit-serial
//   soft clip divider runs. A new word is accepted only when the sequencer is back in S_IDLE.
// Reset (synchronous, rst_n low): registers to 0 / 1 / 0, feedback and stage state zero.
module allpass_cascade_dispersion #(
  parameter int MAX_STAGES = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [apcd_pkg::SAMPLE_W-1:0]    in_sample_in,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [apcd_pkg::SAMPLE_W-1:0]    out_sample_out,
  // configuration write port
  input  logic                                    cfg_we,
  input  logic [apcd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [apcd_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import apcd_pkg::*;

  localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  // ---------------------------------------------------------------------
  // Configuration registers, clamped to their legal range on write.
  // ---------------------------------------------------------------------
  logic signed [COEFF_W-1:0] coeff_r;
  logic [CNT_W-1:0]          count_r;
  logic [GAIN_W-1:0]         gain_r;

  logic signed [COEFF_W-1:0] cfg_coeff;
  logic [CNT_W-1:0]          cfg_count;
  logic [GAIN_W-1:0]         cfg_gain;

  always_comb begin
    cfg_coeff = $signed(cfg_data[COEFF_W-1:0]);
    if (cfg_coeff > $signed(COEFF_W'(COEFF_LIMIT))) begin
      cfg_coeff = COEFF_W'(COEFF_LIMIT);
    end else if (cfg_coeff < -$signed(COEFF_W'(COEFF_LIMIT))) begin
      cfg_coeff = -$signed(COEFF_W'(COEFF_LIMIT));
    end

    cfg_count = cfg_data[CNT_W-1:0];
    if (cfg_count == '0) begin
      cfg_count = CNT_W'(1);
    end else if (CMP_W'(cfg_count) > CMP_W'(MAX_STAGES)) begin
      cfg_count = CNT_W'(MAX_STAGES);
    end

    cfg_gain = cfg_data[GAIN_W-1:0];
    if (cfg_gain > GAIN_W'(GAIN_LIMIT)) begin
      cfg_gain = GAIN_W'(GAIN_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      count_r <= CNT_W'(1);
      gain_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEFF: coeff_r <= cfg_coeff;
        REG_COUNT: count_r <= cfg_count;
        REG_GAIN:  gain_r  <= cfg_gain;
        default:   ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  ap_state_t state_r, state_nxt;

  logic [IDX_W-1:0] idx_r;
  logic [CMP_W-1:0] idx_plus1;
  logic [CMP_W-1:0] count_ext;
  logic             last_stage;
  logic             out_valid_r;
  logic             out_free;
  logic             div_done;

  logic in_take;
  logic mem_rd;
  logic mem_we;
  logic out_load;
  logic div_start;
  logic fb_load;

  assign idx_plus1  = CMP_W'(idx_r) + CMP_W'(1);
  assign count_ext  = CMP_W'(count_r);
  assign last_stage = (idx_plus1 == count_ext);
  // The output slot is free when empty or being drained this cycle.
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_FB_MUL;
      S_FB_MUL: state_nxt = S_FB_ADD;
      S_FB_ADD: state_nxt = S_RD;
      S_RD:     state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ACC;
      S_ACC:    state_nxt = last_stage ? S_PUT : S_RD;
      S_PUT:    if (out_free) state_nxt = S_SQ;
      S_SQ:     state_nxt = S_KMUL;
      S_KMUL:   state_nxt = S_DEN;
      S_DEN:    state_nxt = S_DIV_GO;
      S_DIV_GO: state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    fb_load   = 1'b0;
    unique case (state_r)
      S_IDLE:   in_stall  = 1'b0;
      S_RD:     mem_rd    = 1'b1;
      S_ACC:    mem_we    = 1'b1;
      S_PUT:    out_load  = out_free;
      S_DIV_GO: div_start = 1'b1;
      S_DIV:    fb_load   = div_done;
      default:  ;
    endcase
  end

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FB_ADD) begin
        idx_r <= '0;
      end else if (mem_we) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage state memory: {prev_input, prev_output} per stage, registered
  // synchronous read. Valid bits make never-written entries read as zero.
  // A stage's entry is written in S_ACC and the next read goes to the next
  // stage, so a read never meets a pending write to the same entry.
  // ---------------------------------------------------------------------
  logic [2*ST_W-1:0]     stage_mem [MAX_STAGES];
  logic [MAX_STAGES-1:0] valid_r;
  logic [2*ST_W-1:0]     rd_data_r;
  logic                  rd_valid_r;
  logic [2*ST_W-1:0]     rd_entry;
  logic signed [ST_W-1:0] y_val;
  logic signed [ST_W-1:0] cur_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stage_mem[idx_r] <= {cur_r, y_val};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data_r  <= stage_mem[idx_r];
      rd_valid_r <= valid_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  assign rd_entry = rd_valid_r ? rd_data_r : '0;

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic signed [ST_W-1:0]      fb_r;
  logic signed [48:0]          fb_prod_r;
  logic signed [49:0]          prod_r;
  logic signed [ST_W-1:0]      xprev_r;
  logic signed [SAMPLE_W-1:0]  out_sample_r;
  logic [2*ST_W-1:0]           sq_r;
  logic [52:0]                 kprod_r;
  logic [DEN_W-1:0]            den_r;
  logic [ST_W-1:0]             mag_r;
  logic                        neg_r;

  logic signed [WIDE_W-1:0]    fb_round;
  logic signed [WIDE_W-1:0]    x_sum;
  logic signed [ST_W-1:0]      y_prev;
  logic signed [ST_W:0]        diff;
  logic signed [49:0]          prod;
  logic signed [WIDE_W-1:0]    t_round;
  logic signed [WIDE_W-1:0]    y_sum;
  logic signed [ST_W:0]        o_sum;
  logic signed [ST_W:0]        o_shift;
  logic signed [SAMPLE_W-1:0]  o_sat;
  logic [ST_W:0]               mag_wide;
  logic [14:0]                 clip_k;
  logic [52:0]                 kprod;
  logic [52:0]                 k_round;
  logic [DEN_W-1:0]            den_nxt;
  logic [DVD_W-1:0]            dividend;
  logic [Q_W-1:0]              quotient;
  logic signed [ST_W-1:0]      fb_val;

  always_comb begin
    // Feedback term: round (gain * fb) to nearest, ties up, >> 16; add the
    // widened sample (Q1.23 -> Q6.26 is a shift by three).
    fb_round = $signed({{(WIDE_W-49){fb_prod_r[48]}}, fb_prod_r} + WIDE_W'(32768)) >>> 16;
    x_sum    = $signed({{(WIDE_W-SAMPLE_W-3){sample_r[SAMPLE_W-1]}}, sample_r, 3'b000})
             + fb_round;

    // Allpass stage: y = round(a * (x - y_prev) >> 16) + x_prev.
    y_prev  = $signed(rd_entry[ST_W-1:0]);
    diff    = $signed({cur_r[ST_W-1], cur_r}) - $signed({y_prev[ST_W-1], y_prev});
    prod    = coeff_r * diff;
    t_round = $signed({prod_r[49], prod_r} + WIDE_W'(32768)) >>> 16;
    y_sum   = t_round + $signed({{(WIDE_W-ST_W){xprev_r[ST_W-1]}}, xprev_r});
    y_val   = sat32(y_sum);

    // Output: round away three fraction bits, saturate to 24 bits.
    o_sum   = $signed({cur_r[ST_W-1], cur_r}) + (ST_W+1)'(4);
    o_shift = o_sum >>> 3;
    if (o_shift > $signed((ST_W+1)'(8388607))) begin
      o_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (o_shift < -$signed((ST_W+1)'(8388608))) begin
      o_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      o_sat = o_shift[SAMPLE_W-1:0];
    end

    // Soft clip: den = 2^26 + round(0.3 * floor(x^2 / 2^26)),
    // fb = sign * round(|x| * 2^26 / den), ties away from zero.
    mag_wide = cur_r[ST_W-1] ? ((ST_W+1)'(0) - {1'b1, cur_r}) : {1'b0, cur_r};
    clip_k   = 15'(CLIP_K);
    kprod    = clip_k * sq_r[2*ST_W-1:FRAC_W];
    k_round  = kprod_r + 53'd32768;
    den_nxt  = DEN_W'(1 << FRAC_W) + DEN_W'(k_round >> 16);
    dividend = DVD_W'({mag_r, {FRAC_W{1'b0}}}) + DVD_W'(den_r >> 1);
    fb_val   = neg_r ? (ST_W'(0) - ST_W'(quotient)) : ST_W'(quotient);
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_sample_in;
    end
    if (state_r == S_FB_MUL) begin
      fb_prod_r <= $signed({1'b0, gain_r}) * fb_r;
    end
    if (state_r == S_FB_ADD) begin
      cur_r <= sat32(x_sum);
    end else if (mem_we) begin
      cur_r <= y_val;
    end
    if (state_r == S_MUL) begin
      prod_r  <= prod;
      xprev_r <= $signed(rd_entry[2*ST_W-1:ST_W]);
    end
    if (out_load) begin
      out_sample_r <= o_sat;
    end
    if (state_r == S_SQ) begin
      sq_r  <= mag_wide[ST_W-1:0] * mag_wide[ST_W-1:0];
      mag_r <= mag_wide[ST_W-1:0];
      neg_r <= cur_r[ST_W-1];
    end
    if (state_r == S_KMUL) begin
      kprod_r <= kprod;
    end
    if (state_r == S_DEN) begin
      den_r <= den_nxt;
    end
  end

  // Feedback value and output handshake are control-visible state: reset them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fb_load) begin
        fb_r <= fb_val;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  apcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_take_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_FB_MUL))
    else $error("accepted word did not start the sequencer");

  a_stage_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (idx_plus1 <= count_ext))
    else $error("stage index ran past stage count");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the wait state");

endmodule
